FILE: hw/rtl/tcw_pkg.sv
package tcw_pkg;

	// Screen geometry
	localparam int SCREEN_COLS = 80;
	localparam int SCREEN_ROWS = 25;
	localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;

	// Memory address, sweep counter and linear index widths
	localparam int ADDR_W = $clog2(CELL_COUNT);
	localparam int CNT_W  = $clog2(CELL_COUNT + 1);
	localparam int IDX_W  = (CNT_W > 11) ? CNT_W : 11;

	// Field widths
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int CELL_W = 16;

	// Cell contents
	localparam logic [7:0] RESET_ATTR = 8'h07;
	localparam logic [7:0] BLANK_CHAR = 8'h20;
	localparam logic [7:0] FIRST_PRINT = 8'd32;

	// Control characters
	localparam logic [7:0] CHAR_BS = 8'd8;
	localparam logic [7:0] CHAR_HT = 8'd9;
	localparam logic [7:0] CHAR_LF = 8'd10;
	localparam logic [7:0] CHAR_CR = 8'd13;

	typedef enum logic [1:0] {
		CMD_PUT   = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_SET   = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_COPY,
		ST_BLANK,
		ST_DONE
	} state_t;

	// Linear cell index of a row and column
	function automatic logic [IDX_W-1:0] cell_index(input logic [ROW_W-1:0] r,
			input logic [COL_W-1:0] c);
		cell_index = IDX_W'(r) * IDX_W'(SCREEN_COLS) + IDX_W'(c);
	endfunction

endpackage

FILE: hw/rtl/text_console_writer.sv
// Text console writer: a character-cell screen store and a cursor.
// Input channel s_*: one command per transfer (tuser = command, tdata = char,
// column, row). Output channel m_*: exactly one result per command giving
// the cursor, its linear position and, for a read, the cell read.
// cfg_we/cfg_wdata write the attribute byte used for written and blanked cells.
// Cells live in one dual-port RAM (one write, one registered read port).
// From the accepting edge to the result appearing on m_tvalid, the states are:
//   put character, set cursor: EXEC, DONE; read cell: EXEC, READ, DONE;
//   put character that scrolls: EXEC, COPY (row copy at one cell per cycle
//   through the RAM), BLANK (the last row is blanked), DONE;
//   clear screen: EXEC, BLANK (one RAM write per cycle), DONE.
// One command is in work at a time and the next is taken once the result
// sits in the output register. A stalled receiver holds that register and
// stops input once a second result is ready.
// After reset the block writes all CELL_COUNT (2000) cells blank with
// attribute 7 and takes no command; configuration writes are taken.
// The cursor resets to row 0, column 0 and the attribute to 7.
module text_console_writer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // char_code[7:0], col[15:8], row[23:16]
	input  logic [1:0]  s_tuser,   // command[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // cursor_col[6:0], cursor_row[11:7],
	                               // cursor_pos[22:12], cell_data[38:23], zero[39]
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);

	tcw_pkg::state_t state_q, state_d;

	// Cell RAM
	logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELL_COUNT];
	logic [tcw_pkg::CELL_W-1:0] rd_data_q;
	logic [tcw_pkg::ADDR_W-1:0] raddr, waddr;
	logic [tcw_pkg::CELL_W-1:0] wdata;
	logic                       we;

	// Command and cursor registers
	tcw_pkg::cmd_t              cmd_q;
	logic [7:0]                 char_q, col_in_q, row_in_q;
	logic [tcw_pkg::COL_W-1:0]  cur_col_q, col_d;
	logic [tcw_pkg::ROW_W-1:0]  cur_row_q, row_d;
	logic [7:0]                 attr_q;
	logic [tcw_pkg::CELL_W-1:0] cell_q, sweep_val_q, sweep_val_d;
	logic [tcw_pkg::CNT_W-1:0]  cnt_q, cnt_d;
	logic                       cur_ld, cell_ld, sweep_ld;

	// Copy pipeline for scrolling
	logic                       copy_rd;
	logic                       copy_v_s1;
	logic [tcw_pkg::ADDR_W-1:0] copy_wa_s1;

	// Output register
	logic                       out_valid_q, out_ld;
	logic [tcw_pkg::COL_W-1:0]  out_col_q;
	logic [tcw_pkg::ROW_W-1:0]  out_row_q;
	logic [10:0]                out_pos_q;
	logic [tcw_pkg::CELL_W-1:0] out_cell_q;
	logic [tcw_pkg::IDX_W-1:0]  pos_idx;

	assign s_tready = (state_q == tcw_pkg::ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_cell_q, out_pos_q, out_row_q, out_col_q};
	assign pos_idx  = tcw_pkg::cell_index(cur_row_q, cur_col_q);

	// Next state, RAM control and cursor update
	always_comb begin
		logic [tcw_pkg::CELL_W-1:0] blank;
		logic [7:0]                 col8, nc;
		logic [5:0]                 nr;
		logic [tcw_pkg::COL_W-1:0]  wcol, clamp_c;
		logic [tcw_pkg::ROW_W-1:0]  clamp_r;
		logic [tcw_pkg::IDX_W-1:0]  idx;
		logic                       scroll;

		blank   = {attr_q, tcw_pkg::BLANK_CHAR};
		col8    = {1'b0, cur_col_q};
		nc      = col8;
		nr      = {1'b0, cur_row_q};
		wcol    = cur_col_q;
		scroll  = 1'b0;
		clamp_c = (col_in_q > 8'(tcw_pkg::SCREEN_COLS - 1)) ?
			tcw_pkg::COL_W'(tcw_pkg::SCREEN_COLS - 1) : col_in_q[tcw_pkg::COL_W-1:0];
		clamp_r = (row_in_q > 8'(tcw_pkg::SCREEN_ROWS - 1)) ?
			tcw_pkg::ROW_W'(tcw_pkg::SCREEN_ROWS - 1) : row_in_q[tcw_pkg::ROW_W-1:0];

		state_d     = state_q;
		cnt_d       = cnt_q;
		col_d       = cur_col_q;
		row_d       = cur_row_q;
		cur_ld      = 1'b0;
		cell_ld     = 1'b0;
		sweep_ld    = 1'b0;
		sweep_val_d = blank;
		we          = 1'b0;
		wdata       = blank;
		copy_rd     = 1'b0;
		out_ld      = 1'b0;
		idx         = tcw_pkg::cell_index(cur_row_q, cur_col_q);
		raddr       = cnt_q[tcw_pkg::ADDR_W-1:0];
		waddr       = cnt_q[tcw_pkg::ADDR_W-1:0];

		case (state_q)
			tcw_pkg::ST_INIT, tcw_pkg::ST_BLANK: begin
				we    = 1'b1;
				wdata = sweep_val_q;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT - 1)) begin
					state_d = (state_q == tcw_pkg::ST_INIT) ?
						tcw_pkg::ST_IDLE : tcw_pkg::ST_DONE;
				end
			end
			tcw_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_d = tcw_pkg::ST_EXEC;
				end
			end
			tcw_pkg::ST_EXEC: begin
				cur_ld  = 1'b1;
				state_d = tcw_pkg::ST_DONE;
				case (cmd_q)
					tcw_pkg::CMD_PUT: begin
						if (char_q == tcw_pkg::CHAR_CR) begin
							nc = 8'd0;
						end else if (char_q == tcw_pkg::CHAR_LF) begin
							nc = 8'd0;
							nr = nr + 6'd1;
						end else if (char_q == tcw_pkg::CHAR_HT) begin
							nc = (col8 + 8'd8) & ~8'd7;
						end else if (char_q == tcw_pkg::CHAR_BS) begin
							if (cur_col_q != '0) begin
								nc   = col8 - 8'd1;
								wcol = cur_col_q - 1'b1;
								we   = 1'b1;
							end
						end else if (char_q >= tcw_pkg::FIRST_PRINT) begin
							we    = 1'b1;
							wdata = {attr_q, char_q};
							nc    = col8 + 8'd1;
						end
						// column wrap, then scroll past the bottom row
						if (nc >= 8'(tcw_pkg::SCREEN_COLS)) begin
							nc = 8'd0;
							nr = nr + 6'd1;
						end
						if (nr >= 6'(tcw_pkg::SCREEN_ROWS)) begin
							scroll = 1'b1;
							nr     = 6'(tcw_pkg::SCREEN_ROWS - 1);
						end
						idx   = tcw_pkg::cell_index(cur_row_q, wcol);
						waddr = idx[tcw_pkg::ADDR_W-1:0];
						col_d = nc[tcw_pkg::COL_W-1:0];
						row_d = nr[tcw_pkg::ROW_W-1:0];
						if (scroll) begin
							state_d = tcw_pkg::ST_COPY;
							cnt_d   = tcw_pkg::CNT_W'(tcw_pkg::SCREEN_COLS);
						end
					end
					tcw_pkg::CMD_CLEAR: begin
						col_d    = '0;
						row_d    = '0;
						cnt_d    = '0;
						sweep_ld = 1'b1;
						state_d  = tcw_pkg::ST_BLANK;
					end
					tcw_pkg::CMD_SET: begin
						col_d = clamp_c;
						row_d = clamp_r;
					end
					tcw_pkg::CMD_READ: begin
						idx     = tcw_pkg::cell_index(clamp_r, clamp_c);
						raddr   = idx[tcw_pkg::ADDR_W-1:0];
						state_d = tcw_pkg::ST_READ;
					end
					default: ;
				endcase
			end
			tcw_pkg::ST_READ: begin
				cell_ld = 1'b1;
				state_d = tcw_pkg::ST_DONE;
			end
			tcw_pkg::ST_COPY: begin
				// read one row ahead; the write lands in the next cycle
				if (cnt_q == tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT)) begin
					cnt_d    = tcw_pkg::CNT_W'((tcw_pkg::SCREEN_ROWS - 1) * tcw_pkg::SCREEN_COLS);
					sweep_ld = 1'b1;
					state_d  = tcw_pkg::ST_BLANK;
				end else begin
					copy_rd = 1'b1;
					cnt_d   = cnt_q + 1'b1;
				end
			end
			tcw_pkg::ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					out_ld  = 1'b1;
					state_d = tcw_pkg::ST_IDLE;
				end
			end
			default: state_d = tcw_pkg::ST_IDLE;
		endcase

		// copy write back has the port to itself during the scroll
		if (copy_v_s1) begin
			we    = 1'b1;
			waddr = copy_wa_s1;
			wdata = rd_data_q;
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcw_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Cell RAM
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_data_q <= mem[raddr];
	end

	// Control and cursor registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			attr_q      <= tcw_pkg::RESET_ATTR;
			sweep_val_q <= {tcw_pkg::RESET_ATTR, tcw_pkg::BLANK_CHAR};
			copy_v_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			cnt_q     <= cnt_d;
			copy_v_s1 <= copy_rd;
			if (cfg_we) begin
				attr_q <= cfg_wdata;
			end
			if (cur_ld) begin
				cur_col_q <= col_d;
				cur_row_q <= row_d;
			end
			if (sweep_ld) begin
				sweep_val_q <= sweep_val_d;
			end
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		copy_wa_s1 <= cnt_q[tcw_pkg::ADDR_W-1:0] - tcw_pkg::ADDR_W'(tcw_pkg::SCREEN_COLS);
		if (s_tvalid && s_tready) begin
			cmd_q    <= tcw_pkg::cmd_t'(s_tuser);
			char_q   <= s_tdata[7:0];
			col_in_q <= s_tdata[15:8];
			row_in_q <= s_tdata[23:16];
			cell_q   <= '0;
		end else if (cell_ld) begin
			cell_q <= rd_data_q;
		end
		if (out_ld) begin
			out_col_q  <= cur_col_q;
			out_row_q  <= cur_row_q;
			out_pos_q  <= pos_idx[10:0];
			out_cell_q <= cell_q;
		end
	end

	// Cursor never leaves the screen
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_col_q < tcw_pkg::COL_W'(tcw_pkg::SCREEN_COLS)) &&
		(cur_row_q < tcw_pkg::ROW_W'(tcw_pkg::SCREEN_ROWS)))
		else $error("cursor out of range");

	// Scroll copy writes only rows above the last one
	a_copy_target: assert property (@(posedge clk) disable iff (!arst_n)
		copy_v_s1 |-> (copy_wa_s1 <
			tcw_pkg::ADDR_W'((tcw_pkg::SCREEN_ROWS - 1) * tcw_pkg::SCREEN_COLS)))
		else $error("scroll copy writes into the last row");

	// The copy write never hits the cell being read in the same cycle
	a_copy_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(copy_v_s1 && copy_rd) |-> (copy_wa_s1 != raddr))
		else $error("scroll copy read and write collide");

	// One command in work at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second command taken while busy");

	// A result is never loaded over one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_ld |-> (!out_valid_q || m_tready))
		else $error("result overwritten");

endmodule
